// ----- rtl/core/kfsm_pkg.sv -----
package kfsm_pkg;

  localparam int DIM_DEF = 2;
  localparam int QW      = 32;
  localparam int FRAC    = 16;
  localparam int ACC_W   = 52;
  localparam int PROD_W  = 64;
  localparam int DVD_W   = 48;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_PREDICT = 2'd1;
  localparam logic [1:0] MODE_CORRECT = 2'd2;

  localparam logic [2:0] TGT_A = 3'd0;
  localparam logic [2:0] TGT_Q = 3'd1;
  localparam logic [2:0] TGT_H = 3'd2;
  localparam logic [2:0] TGT_R = 3'd3;
  localparam logic [2:0] TGT_X = 3'd4;
  localparam logic [2:0] TGT_P = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        target;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [31:0] value;
    logic signed [31:0] measurement;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] state_value;
    logic signed [31:0] variance_value;
    logic signed [31:0] innovation;
    logic signed [31:0] innovation_variance;
    logic               corrected;
    logic               singular;
    logic               saturated;
    logic               last;
  } out_item_t;

  // x0 = A x, T = A P, P0 = T A' + Q, then the correct sequence
  typedef enum logic [3:0] {
    PH_X0, PH_AP, PH_P0, PH_PHT, PH_S, PH_GAIN, PH_INN, PH_XU, PH_IKH, PH_PU, PH_EMIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_WB, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] i;
    logic [2:0] j;
    logic [2:0] k;
    logic       load_en;
    logic       run_start;
    logic       corrected;
    logic       mul_en;
    logic       acc_en;
    logic       wb_en;
    logic       div_start;
    logic       emit_en;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  typedef struct packed {
    logic multi_i;
    logic multi_j;
    logic multi_k;
  } loop_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } sat_t;

  function automatic loop_t loop_of(phase_t ph);
    loop_t l;
    unique case (ph)
      PH_X0, PH_PHT:        l = '{multi_i: 1'b1, multi_j: 1'b0, multi_k: 1'b1};
      PH_AP, PH_P0, PH_PU:  l = '{multi_i: 1'b1, multi_j: 1'b1, multi_k: 1'b1};
      PH_S, PH_INN:         l = '{multi_i: 1'b0, multi_j: 1'b0, multi_k: 1'b1};
      PH_GAIN, PH_XU, PH_EMIT: l = '{multi_i: 1'b1, multi_j: 1'b0, multi_k: 1'b0};
      PH_IKH:               l = '{multi_i: 1'b1, multi_j: 1'b1, multi_k: 1'b0};
      default:              l = '0;
    endcase
    return l;
  endfunction

  function automatic phase_t phase_after(phase_t ph);
    phase_t n;
    unique case (ph)
      PH_X0:   n = PH_AP;
      PH_AP:   n = PH_P0;
      PH_PHT:  n = PH_S;
      PH_S:    n = PH_GAIN;
      PH_GAIN: n = PH_INN;
      PH_INN:  n = PH_XU;
      PH_XU:   n = PH_IKH;
      PH_IKH:  n = PH_PU;
      default: n = PH_EMIT;
    endcase
    return n;
  endfunction

  function automatic sat_t sat32(logic signed [ACC_W-1:0] v);
    sat_t s;
    if ((&v[ACC_W-1:QW-1]) || !(|v[ACC_W-1:QW-1])) begin
      s.val = v[QW-1:0];
      s.hit = 1'b0;
    end else begin
      s.val = v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      s.hit = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/kfsm_div.sv -----
module kfsm_div
  import kfsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [QW-1:0]    divisor,
  output logic                    done,
  output logic signed [QW-1:0]    quo,
  output logic                    quo_sat
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0]    dsr_r, dsr_nxt;
  logic             neg_r, neg_nxt;
  logic [QW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dsr_nxt  = divisor[QW-1] ? QW'(-divisor) : QW'(divisor);
      neg_nxt  = dividend[DVD_W-1] ^ divisor[QW-1];
    end else if (busy_r) begin
      rem_nxt = ge ? QW'(rem_sh - {1'b0, dsr_r}) : rem_sh[QW-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  // truncate toward zero, then clamp
  always_comb begin
    if (!neg_r && (dvd_r > DVD_W'(32'h7fff_ffff))) begin
      quo     = 32'sh7fff_ffff;
      quo_sat = 1'b1;
    end else if (neg_r && (dvd_r > DVD_W'(33'h0_8000_0000))) begin
      quo     = 32'sh8000_0000;
      quo_sat = 1'b1;
    end else begin
      quo     = neg_r ? QW'(-dvd_r) : QW'(dvd_r);
      quo_sat = 1'b0;
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/core/kfsm_dp.sv -----
module kfsm_dp
  import kfsm_pkg::*;
#(
  parameter int STATE_DIM = DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
  localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(65536);

  logic signed [QW-1:0] a_r  [STATE_DIM][STATE_DIM];
  logic signed [QW-1:0] q_r  [STATE_DIM][STATE_DIM];
  logic signed [QW-1:0] p_r  [STATE_DIM][STATE_DIM];
  logic signed [QW-1:0] p0_r [STATE_DIM][STATE_DIM];
  logic signed [QW-1:0] t_r  [STATE_DIM][STATE_DIM];
  logic signed [QW-1:0] h_r  [STATE_DIM];
  logic signed [QW-1:0] x_r  [STATE_DIM];
  logic signed [QW-1:0] x0_r [STATE_DIM];
  logic signed [QW-1:0] v_r  [STATE_DIM];
  logic signed [QW-1:0] g_r  [STATE_DIM];
  logic signed [QW-1:0] r_r, s_r, inn_r, z_r;
  logic                 sat_r, sing_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [IW-1:0]        ii, jj, kk, ri, ci;
  logic                 row_ok, col_ok;
  logic signed [QW-1:0] op_a, op_b;
  logic signed [ACC_W-1:0] init_v;
  logic                 sub;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  term, acc_nxt;
  sat_t                 wb;
  logic                 div_done, div_sat;
  logic signed [QW-1:0] div_q;

  assign ii = cmd.i[IW-1:0];
  assign jj = cmd.j[IW-1:0];
  assign kk = cmd.k[IW-1:0];
  assign ri = in_item.row[IW-1:0];
  assign ci = in_item.col[IW-1:0];
  assign row_ok = {1'b0, in_item.row} < 4'(STATE_DIM);
  assign col_ok = {1'b0, in_item.col} < 4'(STATE_DIM);

  kfsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({v_r[ii], {FRAC{1'b0}}}),
    .divisor  (s_r),
    .done     (div_done),
    .quo      (div_q),
    .quo_sat  (div_sat)
  );

  assign stat.div_done = div_done;

  // operand and accumulator-seed selection per phase
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    init_v = '0;
    sub    = 1'b0;
    unique case (cmd.phase)
      PH_X0: begin
        op_a = a_r[ii][kk];
        op_b = x_r[kk];
      end
      PH_AP: begin
        op_a = a_r[ii][kk];
        op_b = p_r[kk][jj];
      end
      PH_P0: begin
        op_a   = t_r[ii][kk];
        op_b   = a_r[jj][kk];
        init_v = {{(ACC_W-QW){q_r[ii][jj][QW-1]}}, q_r[ii][jj]};
      end
      PH_PHT: begin
        op_a = p0_r[ii][kk];
        op_b = h_r[kk];
      end
      PH_S: begin
        op_a   = h_r[kk];
        op_b   = v_r[kk];
        init_v = {{(ACC_W-QW){r_r[QW-1]}}, r_r};
      end
      PH_INN: begin
        op_a   = h_r[kk];
        op_b   = x0_r[kk];
        init_v = {{(ACC_W-QW){z_r[QW-1]}}, z_r};
        sub    = 1'b1;
      end
      PH_XU: begin
        op_a   = g_r[ii];
        op_b   = inn_r;
        init_v = {{(ACC_W-QW){x0_r[ii][QW-1]}}, x0_r[ii]};
      end
      PH_IKH: begin
        op_a   = g_r[ii];
        op_b   = h_r[jj];
        init_v = (ii == jj) ? ONE_Q : '0;
        sub    = 1'b1;
      end
      PH_PU: begin
        op_a = t_r[ii][kk];
        op_b = p0_r[kk][jj];
      end
      default: ;
    endcase
  end

  // round to nearest, ties up: floor((p + 2^15) / 2^16)
  assign rnd     = (prod_r + PROD_W'(32768)) >>> FRAC;
  assign term    = sub ? -rnd[ACC_W-1:0] : rnd[ACC_W-1:0];
  assign acc_nxt = ((cmd.k == 3'd0) ? init_v : acc_r) + term;
  assign wb      = sat32(acc_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= op_a * op_b;
    if (cmd.acc_en) acc_r <= acc_nxt;
    if (cmd.run_start) z_r <= in_item.measurement;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < STATE_DIM; r++) begin
        for (int c = 0; c < STATE_DIM; c++) begin
          a_r[r][c]  <= '0;
          q_r[r][c]  <= '0;
          p_r[r][c]  <= '0;
          p0_r[r][c] <= '0;
          t_r[r][c]  <= '0;
        end
        h_r[r]  <= '0;
        x_r[r]  <= '0;
        x0_r[r] <= '0;
        v_r[r]  <= '0;
        g_r[r]  <= '0;
      end
      r_r    <= '0;
      s_r    <= '0;
      inn_r  <= '0;
      sat_r  <= 1'b0;
      sing_r <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        case (in_item.target)
          TGT_A: if (row_ok && col_ok) a_r[ri][ci] <= in_item.value;
          TGT_Q: if (row_ok && col_ok) q_r[ri][ci] <= in_item.value;
          TGT_H: if (in_item.row == 3'd0 && col_ok) h_r[ci] <= in_item.value;
          TGT_R: if (in_item.row == 3'd0 && in_item.col == 3'd0) r_r <= in_item.value;
          TGT_X: if (in_item.col == 3'd0 && row_ok) x_r[ri] <= in_item.value;
          TGT_P: if (row_ok && col_ok) p_r[ri][ci] <= in_item.value;
          default: ;
        endcase
      end
      if (cmd.run_start) begin
        sat_r  <= 1'b0;
        sing_r <= 1'b0;
      end
      if (cmd.wb_en) begin
        if (cmd.phase == PH_GAIN) begin
          g_r[ii] <= div_q;
          if (div_sat) sat_r <= 1'b1;
        end else begin
          if (wb.hit) sat_r <= 1'b1;
          unique case (cmd.phase)
            PH_X0:  x0_r[ii] <= wb.val;
            PH_AP:  t_r[ii][jj] <= wb.val;
            PH_P0:  p0_r[ii][jj] <= wb.val;
            PH_PHT: v_r[ii] <= wb.val;
            PH_S: begin
              // replace a zero innovation variance by one LSB
              if (wb.val == '0) begin
                s_r    <= 32'sd1;
                sing_r <= 1'b1;
              end else begin
                s_r <= wb.val;
              end
            end
            PH_INN: inn_r <= wb.val;
            PH_XU:  x_r[ii] <= wb.val;
            PH_IKH: t_r[ii][jj] <= wb.val;
            PH_PU:  p_r[ii][jj] <= wb.val;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_en;
    end
    if (cmd.emit_en) begin
      out_item_r.index               <= cmd.i;
      out_item_r.state_value         <= cmd.corrected ? x_r[ii] : x0_r[ii];
      out_item_r.variance_value      <= cmd.corrected ? p_r[ii][ii] : p0_r[ii][ii];
      out_item_r.innovation          <= cmd.corrected ? inn_r : '0;
      out_item_r.innovation_variance <= cmd.corrected ? s_r : '0;
      out_item_r.corrected           <= cmd.corrected;
      out_item_r.singular            <= cmd.corrected & sing_r;
      out_item_r.saturated           <= sat_r;
      out_item_r.last                <= cmd.i == 3'(STATE_DIM - 1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/kfsm_ctrl.sv -----
module kfsm_ctrl
  import kfsm_pkg::*;
#(
  parameter int STATE_DIM = DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] mode,
  input  stat_t      stat,
  output logic       busy,
  output cmd_t       cmd
);

  localparam logic [2:0] LAST_IDX = 3'(STATE_DIM - 1);

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic       corr_r, corr_nxt;
  loop_t      lp;
  logic       i_last, j_last, k_last, run_go;
  phase_t     ph_after;

  assign lp       = loop_of(phase_r);
  assign i_last   = !lp.multi_i || (i_r == LAST_IDX);
  assign j_last   = !lp.multi_j || (j_r == LAST_IDX);
  assign k_last   = !lp.multi_k || (k_r == LAST_IDX);
  assign run_go   = start && (mode == MODE_PREDICT || mode == MODE_CORRECT);
  assign ph_after = phase_after(phase_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (run_go) state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_ACC;
      ST_ACC:      state_nxt = k_last ? ST_WB : ST_MUL;
      ST_WB: begin
        if (i_last && j_last) begin
          if (ph_after == PH_GAIN)      state_nxt = ST_DIV_GO;
          else if (ph_after == PH_EMIT) state_nxt = ST_EMIT;
          else                          state_nxt = ST_MUL;
        end else begin
          state_nxt = (phase_r == PH_GAIN) ? ST_DIV_GO : ST_MUL;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (stat.div_done) state_nxt = ST_WB;
      ST_EMIT:     if (i_last) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // loop counters and phase
  always_comb begin
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    corr_nxt  = corr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (run_go) begin
          phase_nxt = (mode == MODE_PREDICT) ? PH_X0 : PH_PHT;
          corr_nxt  = (mode == MODE_CORRECT);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_ACC: k_nxt = k_last ? 3'd0 : k_r + 3'd1;
      ST_WB: begin
        if (!j_last) begin
          j_nxt = j_r + 3'd1;
        end else begin
          j_nxt = '0;
          if (!i_last) begin
            i_nxt = i_r + 3'd1;
          end else begin
            i_nxt     = '0;
            phase_nxt = ph_after;
          end
        end
      end
      ST_EMIT: i_nxt = i_last ? 3'd0 : i_r + 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_X0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      corr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      corr_r  <= corr_nxt;
    end
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.phase     = phase_r;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
    cmd.corrected = corr_r;
    busy          = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load_en   = start && (mode == MODE_LOAD);
        cmd.run_start = run_go;
      end
      ST_MUL:      cmd.mul_en    = 1'b1;
      ST_ACC:      cmd.acc_en    = 1'b1;
      ST_WB:       cmd.wb_en     = 1'b1;
      ST_DIV_GO:   cmd.div_start = 1'b1;
      ST_EMIT:     cmd.emit_en   = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/kalman_filter_scalar_meas.sv -----
// Load items are taken while idle and give no result. Predict and correct items
// run as multiply-accumulate dot products, a correct item also as N divides, and
// then give N results; N = STATE_DIM. The single multiplier and the bit-serial
// divider set how long an item runs.
// Results follow in the cycle after their emit step, one per cycle, and cannot be stalled.
// Synchronous active-low reset clears every matrix and vector to zero.
module kalman_filter_scalar_meas
  import kfsm_pkg::*;
#(
  parameter int STATE_DIM = DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t  cmd;
  stat_t stat;

  // sequence the dot products, the divides and the emit run
  kfsm_ctrl #(
    .STATE_DIM (STATE_DIM)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // hold the matrices, the shared multiply-accumulate and the divider
  kfsm_dp #(
    .STATE_DIM (STATE_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- sim/tb_kalman_filter_scalar_meas.sv -----
`default_nettype none

module tb_kalman_filter_scalar_meas;
  import kfsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM      = DIM_DEF;
  localparam int QUIET_MAX = 5000;   // watchdog limit on cycles with no progress
  localparam int TAIL     = 400;     // cycles let pass after the last result

  // Tracks the filter in Q16.16 and holds the results each item should produce.
  class kf_scoreboard;
    int errors;
    out_item_t results_due[$];
    logic signed [31:0] a_m[DIM*DIM], q_m[DIM*DIM], p_m[DIM*DIM], p0_m[DIM*DIM];
    logic signed [31:0] h_v[DIM], x_v[DIM], x0_v[DIM];
    logic signed [31:0] r_s;
    bit clamped;

    function new();
      errors = 0;
      foreach (a_m[n]) begin
        a_m[n] = '0; q_m[n] = '0; p_m[n] = '0; p0_m[n] = '0;
      end
      foreach (h_v[n]) begin
        h_v[n] = '0; x_v[n] = '0; x0_v[n] = '0;
      end
      r_s = '0;
    endfunction

    // Exact product rounded to nearest, ties upward.
    function longint mulq(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 32768;
      return p >>> 16;
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) begin
        clamped = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        clamped = 1'b1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function void push_results(bit corr, bit sing, logic signed [31:0] inn,
                               logic signed [31:0] s);
      out_item_t o;
      for (int i = 0; i < DIM; i++) begin
        o.index = i[2:0];
        o.state_value = corr ? x_v[i] : x0_v[i];
        o.variance_value = corr ? p_m[i*DIM+i] : p0_m[i*DIM+i];
        o.innovation = inn;
        o.innovation_variance = s;
        o.corrected = corr;
        o.singular = sing;
        o.saturated = clamped;
        o.last = (i == DIM - 1);
        results_due.push_back(o);
      end
    endfunction

    function void predict();
      logic signed [31:0] ap[DIM*DIM];
      longint acc;
      clamped = 1'b0;
      for (int i = 0; i < DIM; i++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) acc += mulq(a_m[i*DIM+k], x_v[k]);
        x0_v[i] = clip(acc);
      end
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) begin
          acc = 0;
          for (int k = 0; k < DIM; k++) acc += mulq(a_m[i*DIM+k], p_m[k*DIM+j]);
          ap[i*DIM+j] = clip(acc);
        end
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) begin
          acc = longint'(q_m[i*DIM+j]);
          for (int k = 0; k < DIM; k++) acc += mulq(ap[i*DIM+k], a_m[j*DIM+k]);
          p0_m[i*DIM+j] = clip(acc);
        end
      push_results(1'b0, 1'b0, '0, '0);
    endfunction

    function void correct(logic signed [31:0] z);
      logic signed [31:0] pht[DIM], gain[DIM], ikh[DIM*DIM];
      logic signed [31:0] s, inn;
      longint acc;
      bit sing;
      clamped = 1'b0;
      sing = 1'b0;
      for (int i = 0; i < DIM; i++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) acc += mulq(p0_m[i*DIM+k], h_v[k]);
        pht[i] = clip(acc);
      end
      acc = longint'(r_s);
      for (int k = 0; k < DIM; k++) acc += mulq(h_v[k], pht[k]);
      s = clip(acc);
      // zero innovation variance: fall back to one LSB
      if (s == 0) begin
        s = 32'sd1;
        sing = 1'b1;
      end
      for (int i = 0; i < DIM; i++)
        gain[i] = clip((longint'(pht[i]) * 65536) / longint'(s));
      acc = longint'(z);
      for (int k = 0; k < DIM; k++) acc -= mulq(h_v[k], x0_v[k]);
      inn = clip(acc);
      for (int i = 0; i < DIM; i++)
        x_v[i] = clip(longint'(x0_v[i]) + mulq(gain[i], inn));
      for (int i = 0; i < DIM; i++)
        for (int k = 0; k < DIM; k++)
          ikh[i*DIM+k] = clip((i == k ? 64'sd65536 : 64'sd0) - mulq(gain[i], h_v[k]));
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) begin
          acc = 0;
          for (int k = 0; k < DIM; k++) acc += mulq(ikh[i*DIM+k], p0_m[k*DIM+j]);
          p_m[i*DIM+j] = clip(acc);
        end
      push_results(1'b1, sing, inn, s);
    endfunction

    function void load(in_item_t it);
      bit sq;
      int r, c;
      r = it.row;
      c = it.col;
      sq = (r < DIM) && (c < DIM);
      case (it.target)
        TGT_A: if (sq) a_m[r*DIM+c] = it.value;
        TGT_Q: if (sq) q_m[r*DIM+c] = it.value;
        TGT_H: if (r == 0 && c < DIM) h_v[c] = it.value;
        TGT_R: if (r == 0 && c == 0) r_s = it.value;
        TGT_X: if (c == 0 && r < DIM) x_v[r] = it.value;
        TGT_P: if (sq) p_m[r*DIM+c] = it.value;
        default: ;
      endcase
    endfunction

    function void note_item(in_item_t it);
      case (it.mode)
        MODE_LOAD:    load(it);
        MODE_PREDICT: predict();
        MODE_CORRECT: correct(it.measurement);
        default: ;   // unused mode: drop
      endcase
    endfunction

    function void field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $realtime, got);
        return;
      end
      want = results_due.pop_front();
      field("index", want.index, got.index);
      field("state_value", want.state_value, got.state_value);
      field("variance_value", want.variance_value, got.variance_value);
      field("innovation", want.innovation, got.innovation);
      field("innovation_variance", want.innovation_variance, got.innovation_variance);
      field("corrected", want.corrected, got.corrected);
      field("singular", want.singular, got.singular);
      field("saturated", want.saturated, got.saturated);
      field("last", want.last, got.last);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  kf_scoreboard sb = new();
  bit idling_on = 1'b1;
  int quiet = 0;

  always #5 clk = ~clk;

  kalman_filter_scalar_meas DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Results cannot be held off: check every strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > QUIET_MAX) begin
      $display("tb_kalman_filter_scalar_meas: errors");
      $finish;
    end
  end

  // Present one item, hold it until accepted, then maybe idle for a burst.
  task automatic send(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (idling_on && $urandom_range(0, 9) < 3) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Mostly values within a few units, sometimes anything at all.
  function automatic logic signed [31:0] pick_q();
    if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    return $urandom;
  endfunction

  function automatic in_item_t mk(logic [1:0] mode, logic [2:0] target, int r, int c,
                                  logic signed [31:0] v, logic signed [31:0] z);
    in_item_t it;
    it.mode = mode;
    it.target = target;
    it.row = r[2:0];
    it.col = c[2:0];
    it.value = v;
    it.measurement = z;
    return it;
  endfunction

  task automatic load_rand();
    logic [2:0] t;
    int r, c;
    t = 3'($urandom_range(0, 5));
    r = $urandom_range(0, DIM - 1);
    c = $urandom_range(0, DIM - 1);
    if (t == TGT_H || t == TGT_R) r = 0;
    if (t == TGT_R || t == TGT_X) c = 0;
    send(mk(MODE_LOAD, t, r, c, pick_q(), $urandom));
  endtask

  initial begin
    int sent;
    in_item_t it;
    logic [95:0] raw;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: correct straight after reset gives a zero variance, hence singular.
    send(mk(MODE_CORRECT, TGT_A, 0, 0, 0, 32'sh0001_0000));
    send(mk(MODE_PREDICT, TGT_A, 0, 0, 0, 0));
    // Identity A, unit P, H = [1 0], R = 1; then predict and two corrects on the same x0.
    send(mk(MODE_LOAD, TGT_A, 0, 0, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_A, 1, 1, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_P, 0, 0, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_P, 1, 1, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_H, 0, 0, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_R, 0, 0, 32'sh0001_0000, 0));
    send(mk(MODE_LOAD, TGT_X, 1, 0, 32'sh0002_8000, 0));
    send(mk(MODE_LOAD, TGT_Q, 0, 1, 32'sh0000_4000, 0));
    send(mk(MODE_PREDICT, TGT_A, 0, 0, 0, 0));
    send(mk(MODE_CORRECT, TGT_A, 0, 0, 0, 32'sh0003_0000));
    send(mk(MODE_CORRECT, TGT_A, 0, 0, 0, 32'sh8000_0000));
    // Ignored loads: bad indexes, unused targets, and unused mode 3.
    send(mk(MODE_LOAD, TGT_A, 7, 0, 32'sh7fff_ffff, 0));
    send(mk(MODE_LOAD, TGT_H, 1, 0, 32'sh7fff_ffff, 0));
    send(mk(MODE_LOAD, TGT_R, 0, 1, 32'sh7fff_ffff, 0));
    send(mk(MODE_LOAD, TGT_X, 0, 7, 32'sh7fff_ffff, 0));
    send(mk(MODE_LOAD, 3'd6, 0, 0, 32'sh7fff_ffff, 0));
    send(mk(MODE_LOAD, 3'd7, 0, 0, 32'sh7fff_ffff, 0));
    send(mk(2'd3, 3'd7, 7, 7, 32'shffff_ffff, 32'shffff_ffff));
    // Extremes: drive saturation and a negative variance.
    send(mk(MODE_LOAD, TGT_A, 0, 1, 32'sh8000_0000, 0));
    send(mk(MODE_LOAD, TGT_R, 0, 0, 32'sh8000_0000, 0));
    send(mk(MODE_PREDICT, TGT_A, 0, 0, 0, 0));
    send(mk(MODE_CORRECT, TGT_A, 0, 0, 0, 32'sh7fff_ffff));

    // Random: mostly load/predict/correct sequences, some noise.
    sent = 0;
    while (sent < 370) begin
      if (sent > 300) idling_on = 1'b0;
      // Pause once until every result is in.
      if (sent > 150 && sent < 160) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.results_due.size() != 0);
        sent = 160;
      end
      if ($urandom_range(0, 9) < 2) begin
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        send(it);
        sent++;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          load_rand();
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send(mk(MODE_PREDICT, 3'($urandom), $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send(mk(MODE_CORRECT, 3'($urandom), $urandom, $urandom, $urandom, pick_q()));
          sent++;
        end
      end
    end
    start <= 1'b0;

    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("tb_kalman_filter_scalar_meas: clean");
    end else begin
      $display("tb_kalman_filter_scalar_meas: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
